### hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define WFS_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("wfs assertion failed");

// when pre holds, post must hold in the next cycle
`define WFS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("wfs assertion failed");

`endif

### hw/rtl/wfs_pkg.sv
package wfs_pkg;

	localparam int RANGE_BITS = 16;

	// sqrt2 in q16 and its width
	localparam int SQRT2_Q16 = 92682;
	localparam int K_W = 17;
	// ratio numerator and quotient width
	localparam int N1_W = RANGE_BITS + K_W;
	localparam int RATIO_MAX = 1 << 24;
	localparam int Q_W = 25;
	// signed tangent, q16
	localparam int T_W = 26;
	localparam int ONE_Q16 = 65536;
	// sqrt operand 2^32 + t*t and root
	localparam int V_W = 50;
	localparam int SQ_W = V_W / 2;
	localparam int REM_W = SQ_W + 3;
	// lookahead * t, numerator and its magnitude
	localparam int LAT_W = 16 + 1 + T_W;
	localparam int NUM_W = LAT_W + 1;
	localparam int MAG_W = NUM_W - 1;
	// cross-track error, command error and product
	localparam int E_W = MAG_W - 16 + 2;
	localparam int ERR_W = E_W + 1;
	localparam int P_W = ERR_W + 17;

	// stream widths
	localparam int IN_DATA_W = ((3 * RANGE_BITS + 7) / 8) * 8;
	localparam int IN_USER_W = 3;
	localparam int TURN_W = 11;
	localparam int SPEED_W = 8;
	localparam int OUT_DATA_W = ((TURN_W + SPEED_W + 7) / 8) * 8;

	// configuration
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RATE_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DESIRED  = 3'd0,
		CFG_GAIN     = 3'd1,
		CFG_MAX_TURN = 3'd2,
		CFG_DEADBAND = 3'd3,
		CFG_LOOKAHD  = 3'd4,
		CFG_FRONT    = 3'd5,
		CFG_TIER     = 3'd6
	} cfg_idx_t;

	localparam logic [SPEED_W-1:0] SPEED_SLOW = 8'd5;
	localparam logic [SPEED_W-1:0] SPEED_MID  = 8'd20;
	localparam logic [SPEED_W-1:0] SPEED_FAST = 8'd30;

	// control that travels alongside each item
	typedef struct packed {
		logic vld;
		logic zero_e;
	} side_t;

endpackage

### hw/rtl/wall_follow_steering.sv
// channel   direction  payload
// s_*       in         tdata: right, diag, ahead ranges; tuser: valid flags
// m_*       out        tdata: turn_rate, forward_speed
// cfg_*     in         register write, index and data
//
// one request accepted per cycle while the output is not stalled; the pipeline
// holds the bit-per-stage ratio divider (33), square root (25) and cross-track divider (43).
// reset clears all valid bits and loads register defaults.
// a stall on the output freezes every stage together; nothing is dropped.
module wall_follow_steering (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// right_range, diag_range, ahead_range
	input  logic [wfs_pkg::IN_DATA_W-1:0]        s_tdata,
	// right_valid, diag_valid, ahead_valid
	input  logic [wfs_pkg::IN_USER_W-1:0]        s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// turn_rate, forward_speed, zero pad
	output logic [wfs_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                 cfg_we,
	input  logic [wfs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wfs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [15:0] desired_q, gain_q, lookahead_q, front_q;
	logic [wfs_pkg::RATE_W-1:0] max_turn_q, deadband_q, tier_q;

	logic adv;
	wfs_pkg::side_t side_r, side_h;
	logic signed [wfs_pkg::T_W-1:0] t_r;
	logic [wfs_pkg::RANGE_BITS-1:0] right_r;
	logic signed [wfs_pkg::E_W-1:0] e_h;
	logic out_vld;
	logic [wfs_pkg::TURN_W-1:0] turn;
	logic [wfs_pkg::SPEED_W-1:0] speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_q <= 16'd250;
			gain_q <= 16'd384;
			max_turn_q <= 10'd300;
			deadband_q <= 10'd10;
			lookahead_q <= 16'd200;
			front_q <= 16'd300;
			tier_q <= 10'd124;
		end else if (cfg_we) begin
			unique case (wfs_pkg::cfg_idx_t'(cfg_index))
				wfs_pkg::CFG_DESIRED:  desired_q <= cfg_data;
				wfs_pkg::CFG_GAIN:     gain_q <= cfg_data;
				wfs_pkg::CFG_MAX_TURN: max_turn_q <= cfg_data[wfs_pkg::RATE_W-1:0];
				wfs_pkg::CFG_DEADBAND: deadband_q <= cfg_data[wfs_pkg::RATE_W-1:0];
				wfs_pkg::CFG_LOOKAHD:  lookahead_q <= cfg_data;
				wfs_pkg::CFG_FRONT:    front_q <= cfg_data;
				wfs_pkg::CFG_TIER:     tier_q <= cfg_data[wfs_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv = !out_vld || m_tready;
	assign s_tready = adv;

	wfs_ratio u_ratio (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.in_vld          (s_tvalid),
		.right_range     (s_tdata[wfs_pkg::RANGE_BITS-1:0]),
		.right_valid     (s_tuser[0]),
		.diag_range      (s_tdata[2*wfs_pkg::RANGE_BITS-1:wfs_pkg::RANGE_BITS]),
		.diag_valid      (s_tuser[1]),
		.ahead_range     (s_tdata[3*wfs_pkg::RANGE_BITS-1:2*wfs_pkg::RANGE_BITS]),
		.ahead_valid     (s_tuser[2]),
		.front_reference (front_q),
		.side_o          (side_r),
		.t_o             (t_r),
		.right_o         (right_r)
	);

	wfs_heading u_heading (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.side_i    (side_r),
		.t_i       (t_r),
		.right_i   (right_r),
		.lookahead (lookahead_q),
		.side_o    (side_h),
		.e_o       (e_h)
	);

	wfs_command u_command (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.side_i           (side_h),
		.e_i              (e_h),
		.desired_distance (desired_q),
		.gain_q8          (gain_q),
		.max_turn_rate    (max_turn_q),
		.turn_deadband    (deadband_q),
		.tier_threshold   (tier_q),
		.out_vld          (out_vld),
		.turn_rate        (turn),
		.forward_speed    (speed)
	);

	assign m_tvalid = out_vld;
	assign m_tdata = (wfs_pkg::OUT_DATA_W)'({speed, turn});

endmodule

### hw/rtl/wfs_ratio.sv
module wfs_ratio (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_vld,
	input  logic [wfs_pkg::RANGE_BITS-1:0]       right_range,
	input  logic                                 right_valid,
	input  logic [wfs_pkg::RANGE_BITS-1:0]       diag_range,
	input  logic                                 diag_valid,
	input  logic [wfs_pkg::RANGE_BITS-1:0]       ahead_range,
	input  logic                                 ahead_valid,
	input  logic [15:0]                          front_reference,
	output wfs_pkg::side_t                       side_o,
	output logic signed [wfs_pkg::T_W-1:0]       t_o,
	output logic [wfs_pkg::RANGE_BITS-1:0]       right_o
);

	wfs_pkg::side_t side_s1;
	logic [wfs_pkg::N1_W-1:0] num_s1;
	logic [wfs_pkg::RANGE_BITS-1:0] den_s1, rgt_s1;

	wfs_pkg::side_t side_s2 [wfs_pkg::N1_W];
	logic [wfs_pkg::N1_W-1:0] num_s2 [wfs_pkg::N1_W];
	logic [wfs_pkg::N1_W-1:0] quo_s2 [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS-1:0] rem_s2 [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS-1:0] den_s2 [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS-1:0] rgt_s2 [wfs_pkg::N1_W];

	wfs_pkg::side_t side_s3;
	logic signed [wfs_pkg::T_W-1:0] t_s3;
	logic [wfs_pkg::RANGE_BITS-1:0] rgt_s3;

	logic [wfs_pkg::N1_W-1:0] num_c;
	logic [wfs_pkg::RANGE_BITS-1:0] ahead_c;
	logic zero_c;

	wfs_pkg::side_t src_side [wfs_pkg::N1_W];
	logic [wfs_pkg::N1_W-1:0] src_num [wfs_pkg::N1_W];
	logic [wfs_pkg::N1_W-1:0] src_quo [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS-1:0] src_rem [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS-1:0] src_den [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS-1:0] src_rgt [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS:0] dtmp [wfs_pkg::N1_W];
	logic [wfs_pkg::RANGE_BITS-1:0] nrem [wfs_pkg::N1_W];
	logic nbit [wfs_pkg::N1_W];

	logic [wfs_pkg::N1_W-1:0] q_fin;
	logic [wfs_pkg::Q_W-1:0] qsat_c;

	always_comb begin
		num_c = (wfs_pkg::N1_W)'(right_range) * (wfs_pkg::N1_W)'(wfs_pkg::SQRT2_Q16);
		ahead_c = ahead_valid ? ahead_range : '0;
		zero_c = !(right_valid && diag_valid) || (32'(ahead_c) < 32'(front_reference));
	end

	// one quotient bit per stage, restoring
	always_comb begin
		src_side[0] = side_s1;
		src_num[0] = num_s1;
		src_quo[0] = '0;
		src_rem[0] = '0;
		src_den[0] = den_s1;
		src_rgt[0] = rgt_s1;
		for (int k = 1; k < wfs_pkg::N1_W; k++) begin
			src_side[k] = side_s2[k-1];
			src_num[k] = num_s2[k-1];
			src_quo[k] = quo_s2[k-1];
			src_rem[k] = rem_s2[k-1];
			src_den[k] = den_s2[k-1];
			src_rgt[k] = rgt_s2[k-1];
		end
		for (int k = 0; k < wfs_pkg::N1_W; k++) begin
			dtmp[k] = {src_rem[k], src_num[k][wfs_pkg::N1_W-1-k]};
			if (dtmp[k] >= {1'b0, src_den[k]}) begin
				nrem[k] = (wfs_pkg::RANGE_BITS)'(dtmp[k] - {1'b0, src_den[k]});
				nbit[k] = 1'b1;
			end else begin
				nrem[k] = dtmp[k][wfs_pkg::RANGE_BITS-1:0];
				nbit[k] = 1'b0;
			end
		end
	end

	// zero divisor gives all ones, which saturates as well
	always_comb begin
		q_fin = quo_s2[wfs_pkg::N1_W-1];
		if (q_fin > (wfs_pkg::N1_W)'(wfs_pkg::RATIO_MAX))
			qsat_c = (wfs_pkg::Q_W)'(wfs_pkg::RATIO_MAX);
		else
			qsat_c = q_fin[wfs_pkg::Q_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			for (int k = 0; k < wfs_pkg::N1_W; k++)
				side_s2[k] <= '0;
			side_s3 <= '0;
		end else if (adv) begin
			side_s1 <= '{vld: in_vld, zero_e: zero_c};
			for (int k = 0; k < wfs_pkg::N1_W; k++)
				side_s2[k] <= src_side[k];
			side_s3 <= side_s2[wfs_pkg::N1_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= num_c;
			den_s1 <= diag_range;
			rgt_s1 <= right_range;
			for (int k = 0; k < wfs_pkg::N1_W; k++) begin
				num_s2[k] <= src_num[k];
				quo_s2[k] <= {src_quo[k][wfs_pkg::N1_W-2:0], nbit[k]};
				rem_s2[k] <= nrem[k];
				den_s2[k] <= src_den[k];
				rgt_s2[k] <= src_rgt[k];
			end
			t_s3 <= (wfs_pkg::T_W)'(wfs_pkg::ONE_Q16) - $signed({1'b0, qsat_c});
			rgt_s3 <= rgt_s2[wfs_pkg::N1_W-1];
		end
	end

	assign side_o = side_s3;
	assign t_o = t_s3;
	assign right_o = rgt_s3;

endmodule

### hw/rtl/wfs_heading.sv
module wfs_heading (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  wfs_pkg::side_t                       side_i,
	input  logic signed [wfs_pkg::T_W-1:0]       t_i,
	input  logic [wfs_pkg::RANGE_BITS-1:0]       right_i,
	input  logic [15:0]                          lookahead,
	output wfs_pkg::side_t                       side_o,
	output logic signed [wfs_pkg::E_W-1:0]       e_o
);

	// products
	wfs_pkg::side_t side_s1;
	logic [2*wfs_pkg::T_W-1:0] sq_s1;
	logic signed [wfs_pkg::LAT_W-1:0] lat_s1;
	logic [wfs_pkg::RANGE_BITS-1:0] rgt_s1;

	// sqrt operand and numerator magnitude
	wfs_pkg::side_t side_s2;
	logic [wfs_pkg::V_W-1:0] v_s2;
	logic [wfs_pkg::MAG_W-1:0] mag_s2;
	logic neg_s2;

	// square root, two operand bits per stage
	wfs_pkg::side_t side_s3 [wfs_pkg::SQ_W];
	logic [wfs_pkg::V_W-1:0] v_s3 [wfs_pkg::SQ_W];
	logic [wfs_pkg::SQ_W-1:0] root_s3 [wfs_pkg::SQ_W];
	logic [wfs_pkg::REM_W-1:0] srem_s3 [wfs_pkg::SQ_W];
	logic [wfs_pkg::MAG_W-1:0] mag_s3 [wfs_pkg::SQ_W];
	logic neg_s3 [wfs_pkg::SQ_W];

	// division by the root, one quotient bit per stage
	wfs_pkg::side_t side_s4 [wfs_pkg::MAG_W];
	logic [wfs_pkg::MAG_W-1:0] mag_s4 [wfs_pkg::MAG_W];
	logic [wfs_pkg::MAG_W-1:0] quo_s4 [wfs_pkg::MAG_W];
	logic [wfs_pkg::SQ_W-1:0] rem_s4 [wfs_pkg::MAG_W];
	logic [wfs_pkg::SQ_W-1:0] den_s4 [wfs_pkg::MAG_W];
	logic neg_s4 [wfs_pkg::MAG_W];

	wfs_pkg::side_t side_s5;
	logic signed [wfs_pkg::E_W-1:0] e_s5;

	logic signed [wfs_pkg::NUM_W-1:0] num_c;
	logic [wfs_pkg::V_W-1:0] v_c;

	wfs_pkg::side_t ssrc_side [wfs_pkg::SQ_W];
	logic [wfs_pkg::V_W-1:0] ssrc_v [wfs_pkg::SQ_W];
	logic [wfs_pkg::SQ_W-1:0] ssrc_root [wfs_pkg::SQ_W];
	logic [wfs_pkg::REM_W-1:0] ssrc_rem [wfs_pkg::SQ_W];
	logic [wfs_pkg::MAG_W-1:0] ssrc_mag [wfs_pkg::SQ_W];
	logic ssrc_neg [wfs_pkg::SQ_W];
	logic [wfs_pkg::REM_W-1:0] stmp [wfs_pkg::SQ_W];
	logic [wfs_pkg::REM_W-1:0] strial [wfs_pkg::SQ_W];
	logic [wfs_pkg::REM_W-1:0] snrem [wfs_pkg::SQ_W];
	logic sbit [wfs_pkg::SQ_W];

	wfs_pkg::side_t dsrc_side [wfs_pkg::MAG_W];
	logic [wfs_pkg::MAG_W-1:0] dsrc_mag [wfs_pkg::MAG_W];
	logic [wfs_pkg::MAG_W-1:0] dsrc_quo [wfs_pkg::MAG_W];
	logic [wfs_pkg::SQ_W-1:0] dsrc_rem [wfs_pkg::MAG_W];
	logic [wfs_pkg::SQ_W-1:0] dsrc_den [wfs_pkg::MAG_W];
	logic dsrc_neg [wfs_pkg::MAG_W];
	logic [wfs_pkg::SQ_W:0] dtmp [wfs_pkg::MAG_W];
	logic [wfs_pkg::SQ_W-1:0] dnrem [wfs_pkg::MAG_W];
	logic dbit [wfs_pkg::MAG_W];

	logic [wfs_pkg::MAG_W-1:0] q_fin;
	logic signed [wfs_pkg::E_W-1:0] qmag_c;

	always_comb begin
		v_c = (wfs_pkg::V_W)'(sq_s1) + ((wfs_pkg::V_W)'(1) << 32);
		num_c = $signed({1'b0, (wfs_pkg::NUM_W-1)'({rgt_s1, 16'h0000})})
			+ (wfs_pkg::NUM_W)'(lat_s1);
	end

	always_comb begin
		ssrc_side[0] = side_s2;
		ssrc_v[0] = v_s2;
		ssrc_root[0] = '0;
		ssrc_rem[0] = '0;
		ssrc_mag[0] = mag_s2;
		ssrc_neg[0] = neg_s2;
		for (int k = 1; k < wfs_pkg::SQ_W; k++) begin
			ssrc_side[k] = side_s3[k-1];
			ssrc_v[k] = v_s3[k-1];
			ssrc_root[k] = root_s3[k-1];
			ssrc_rem[k] = srem_s3[k-1];
			ssrc_mag[k] = mag_s3[k-1];
			ssrc_neg[k] = neg_s3[k-1];
		end
		for (int k = 0; k < wfs_pkg::SQ_W; k++) begin
			stmp[k] = {ssrc_rem[k][wfs_pkg::REM_W-3:0],
				ssrc_v[k][wfs_pkg::V_W-1-2*k -: 2]};
			strial[k] = {1'b0, ssrc_root[k], 2'b01};
			if (stmp[k] >= strial[k]) begin
				snrem[k] = stmp[k] - strial[k];
				sbit[k] = 1'b1;
			end else begin
				snrem[k] = stmp[k];
				sbit[k] = 1'b0;
			end
		end
	end

	always_comb begin
		dsrc_side[0] = side_s3[wfs_pkg::SQ_W-1];
		dsrc_mag[0] = mag_s3[wfs_pkg::SQ_W-1];
		dsrc_quo[0] = '0;
		dsrc_rem[0] = '0;
		dsrc_den[0] = root_s3[wfs_pkg::SQ_W-1];
		dsrc_neg[0] = neg_s3[wfs_pkg::SQ_W-1];
		for (int k = 1; k < wfs_pkg::MAG_W; k++) begin
			dsrc_side[k] = side_s4[k-1];
			dsrc_mag[k] = mag_s4[k-1];
			dsrc_quo[k] = quo_s4[k-1];
			dsrc_rem[k] = rem_s4[k-1];
			dsrc_den[k] = den_s4[k-1];
			dsrc_neg[k] = neg_s4[k-1];
		end
		for (int k = 0; k < wfs_pkg::MAG_W; k++) begin
			dtmp[k] = {dsrc_rem[k], dsrc_mag[k][wfs_pkg::MAG_W-1-k]};
			if (dtmp[k] >= {1'b0, dsrc_den[k]}) begin
				dnrem[k] = (wfs_pkg::SQ_W)'(dtmp[k] - {1'b0, dsrc_den[k]});
				dbit[k] = 1'b1;
			end else begin
				dnrem[k] = dtmp[k][wfs_pkg::SQ_W-1:0];
				dbit[k] = 1'b0;
			end
		end
	end

	// quotient is below 2^27, so its low bits carry it whole
	always_comb begin
		q_fin = quo_s4[wfs_pkg::MAG_W-1];
		qmag_c = $signed({1'b0, q_fin[wfs_pkg::E_W-2:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			for (int k = 0; k < wfs_pkg::SQ_W; k++)
				side_s3[k] <= '0;
			for (int k = 0; k < wfs_pkg::MAG_W; k++)
				side_s4[k] <= '0;
			side_s5 <= '0;
		end else if (adv) begin
			side_s1 <= side_i;
			side_s2 <= side_s1;
			for (int k = 0; k < wfs_pkg::SQ_W; k++)
				side_s3[k] <= ssrc_side[k];
			for (int k = 0; k < wfs_pkg::MAG_W; k++)
				side_s4[k] <= dsrc_side[k];
			side_s5 <= side_s4[wfs_pkg::MAG_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// full-width signed square
			sq_s1 <= $unsigned((2*wfs_pkg::T_W)'(t_i) * (2*wfs_pkg::T_W)'(t_i));
			lat_s1 <= $signed({1'b0, lookahead}) * t_i;
			rgt_s1 <= right_i;
			v_s2 <= v_c;
			neg_s2 <= num_c[wfs_pkg::NUM_W-1];
			mag_s2 <= num_c[wfs_pkg::NUM_W-1] ? (wfs_pkg::MAG_W)'(-num_c)
				: (wfs_pkg::MAG_W)'(num_c);
			for (int k = 0; k < wfs_pkg::SQ_W; k++) begin
				v_s3[k] <= ssrc_v[k];
				root_s3[k] <= {ssrc_root[k][wfs_pkg::SQ_W-2:0], sbit[k]};
				srem_s3[k] <= snrem[k];
				mag_s3[k] <= ssrc_mag[k];
				neg_s3[k] <= ssrc_neg[k];
			end
			for (int k = 0; k < wfs_pkg::MAG_W; k++) begin
				mag_s4[k] <= dsrc_mag[k];
				quo_s4[k] <= {dsrc_quo[k][wfs_pkg::MAG_W-2:0], dbit[k]};
				rem_s4[k] <= dnrem[k];
				den_s4[k] <= dsrc_den[k];
				neg_s4[k] <= dsrc_neg[k];
			end
			e_s5 <= neg_s4[wfs_pkg::MAG_W-1] ? -qmag_c : qmag_c;
		end
	end

	assign side_o = side_s5;
	assign e_o = e_s5;

endmodule

### hw/rtl/wfs_command.sv
module wfs_command (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  wfs_pkg::side_t                       side_i,
	input  logic signed [wfs_pkg::E_W-1:0]       e_i,
	input  logic [15:0]                          desired_distance,
	input  logic [15:0]                          gain_q8,
	input  logic [wfs_pkg::RATE_W-1:0]           max_turn_rate,
	input  logic [wfs_pkg::RATE_W-1:0]           turn_deadband,
	input  logic [wfs_pkg::RATE_W-1:0]           tier_threshold,
	output logic                                 out_vld,
	output logic [wfs_pkg::TURN_W-1:0]           turn_rate,
	output logic [wfs_pkg::SPEED_W-1:0]          forward_speed
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [wfs_pkg::ERR_W-1:0] err_s1;
	logic signed [wfs_pkg::P_W-1:0] prod_s2;
	logic [wfs_pkg::P_W-9:0] mag_s3;
	logic neg_s3;
	logic [wfs_pkg::TURN_W-1:0] turn_s4;
	logic [wfs_pkg::SPEED_W-1:0] speed_s4;

	logic signed [wfs_pkg::E_W-1:0] e_c;
	logic [wfs_pkg::P_W-1:0] abs_c;
	logic [wfs_pkg::RATE_W-1:0] clip_c, m_c;
	logic [wfs_pkg::SPEED_W-1:0] speed_c;
	logic [wfs_pkg::TURN_W-1:0] turn_c;

	always_comb begin
		e_c = side_i.zero_e ? '0 : e_i;
		abs_c = prod_s2[wfs_pkg::P_W-1] ? $unsigned(-prod_s2) : $unsigned(prod_s2);
	end

	// clamp, deadband, then speed tier and signed turn from the magnitude
	always_comb begin
		if (mag_s3 > (wfs_pkg::P_W-8)'(max_turn_rate))
			clip_c = max_turn_rate;
		else
			clip_c = mag_s3[wfs_pkg::RATE_W-1:0];
		m_c = (clip_c < turn_deadband) ? '0 : clip_c;
		if (m_c > tier_threshold)
			speed_c = wfs_pkg::SPEED_SLOW;
		else if ({m_c, 2'b00} > 12'(tier_threshold) * 12'd3)
			speed_c = wfs_pkg::SPEED_MID;
		else if ({m_c, 1'b0} > 11'(tier_threshold))
			speed_c = wfs_pkg::SPEED_FAST;
		else
			speed_c = wfs_pkg::SPEED_MID;
		turn_c = neg_s3 ? -(wfs_pkg::TURN_W)'(m_c) : (wfs_pkg::TURN_W)'(m_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= side_i.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= $signed({1'b0, (wfs_pkg::ERR_W-1)'(desired_distance)})
				- (wfs_pkg::ERR_W)'(e_c);
			prod_s2 <= $signed({1'b0, gain_q8}) * err_s1;
			neg_s3 <= prod_s2[wfs_pkg::P_W-1];
			mag_s3 <= abs_c[wfs_pkg::P_W-1:8];
			turn_s4 <= turn_c;
			speed_s4 <= speed_c;
		end
	end

	assign out_vld = vld_s4;
	assign turn_rate = turn_s4;
	assign forward_speed = speed_s4;

endmodule

### hw/rtl/wfs_checker.sv
`include "assert_macros.svh"

module wfs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [wfs_pkg::OUT_DATA_W-1:0]  m_tdata
);

	logic [wfs_pkg::TURN_W-1:0] turn;
	logic [wfs_pkg::SPEED_W-1:0] speed;

	assign turn = m_tdata[wfs_pkg::TURN_W-1:0];
	assign speed = m_tdata[wfs_pkg::TURN_W+wfs_pkg::SPEED_W-1:wfs_pkg::TURN_W];

	`WFS_ASSERT(a_speed_tier, clk, arst_n, !m_tvalid || speed == wfs_pkg::SPEED_SLOW || speed == wfs_pkg::SPEED_MID || speed == wfs_pkg::SPEED_FAST)
	`WFS_ASSERT(a_zero_turn_mid, clk, arst_n, !(m_tvalid && turn == '0) || speed == wfs_pkg::SPEED_MID)
	`WFS_ASSERT(a_ready_follows_out, clk, arst_n, s_tready == (!m_tvalid || m_tready))
	`WFS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind wall_follow_steering wfs_checker u_wfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/sv/wall_follow_steering_test.sv
`timescale 1ns / 100ps

module wall_follow_steering_test;
	import wfs_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1430;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [TURN_W-1:0] turn;
		logic [SPEED_W-1:0]       speed;
	} steer_t;

	typedef struct packed {
		logic [15:0] right;
		logic        right_ok;
		logic [15:0] diag;
		logic        diag_ok;
		logic [15:0] ahead;
		logic        ahead_ok;
		logic        typed;
		steer_t      cmd;
	} scan_row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [IN_USER_W-1:0] s_tuser;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wall_follow_steering dut (.*);

	// register copies
	longint desired_mm, gain, max_turn, deadband, look_mm, front_ref, tier_thr;

	steer_t cmd_q[$];
	steer_t typed_q[$];
	bit typed_flag_q[$];
	int errors;
	int cycles;
	int rx_mode;
	logic next_typed;
	steer_t next_cmd;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic steer_t steer_cmd(input logic [15:0] r, input logic rv,
			input logic [15:0] d, input logic dv, input logic [15:0] a, input logic av);
		longint q, t, num, e, err, prod;
		longint unsigned s, mag, m;
		bit neg;
		steer_t res;
		e = 0;
		if (rv && dv) begin
			if (d == 0)
				q = RATIO_MAX;
			else begin
				q = (longint'(r) * SQRT2_Q16) / longint'(d);
				if (q > RATIO_MAX)
					q = RATIO_MAX;
			end
			t = ONE_Q16 - q;
			s = root64((64'd1 << 32) + longint'(t * t));
			num = (longint'(r) << 16) + look_mm * t;
			mag = (num < 0) ? -num : num;
			e = longint'(mag / s);
			if (num < 0)
				e = -e;
		end
		if ((av ? longint'(a) : 0) < front_ref)
			e = 0;
		err = desired_mm - e;
		prod = gain * err;
		neg = prod < 0;
		m = (neg ? -prod : prod) >> 8;
		if (m > max_turn)
			m = max_turn;
		if (m < deadband)
			m = 0;
		if (m > tier_thr)
			res.speed = SPEED_SLOW;
		else if (4 * m > 3 * tier_thr)
			res.speed = SPEED_MID;
		else if (2 * m > tier_thr)
			res.speed = SPEED_FAST;
		else
			res.speed = SPEED_MID;
		res.turn = TURN_W'(neg ? -m : m);
		return res;
	endfunction

	// scoreboard on both channels
	always @(posedge clk) begin
		steer_t got, want, typed;
		bit has_typed;
		if (arst_n && s_tvalid && s_tready) begin
			cmd_q.push_back(steer_cmd(s_tdata[15:0], s_tuser[0], s_tdata[31:16],
				s_tuser[1], s_tdata[47:32], s_tuser[2]));
			typed_q.push_back(next_cmd);
			typed_flag_q.push_back(next_typed);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.turn = m_tdata[TURN_W-1:0];
			got.speed = m_tdata[TURN_W +: SPEED_W];
			if (cmd_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result turn %0d speed %0d", $time,
					got.turn, got.speed);
			end else begin
				want = cmd_q.pop_front();
				typed = typed_q.pop_front();
				has_typed = typed_flag_q.pop_front();
				if (has_typed)
					want = typed;
				if (got.turn !== want.turn) begin
					errors++;
					$display("%0t turn_rate expected %0d actual %0d", $time,
						want.turn, got.turn);
				end
				if (got.speed !== want.speed) begin
					errors++;
					$display("%0t forward_speed expected %0d actual %0d", $time,
						want.speed, got.speed);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stall pattern, mode changes now and then
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= (cycles % 16) < 11;
		endcase
	end

	task automatic send_scan(input scan_row_t row);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {row.ahead, row.diag, row.right};
		s_tuser <= {row.ahead_ok, row.diag_ok, row.right_ok};
		next_typed <= row.typed;
		next_cmd <= row.cmd;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain;
		pause_sender(0);
		while (cmd_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(v);
		case (idx)
			CFG_DESIRED:  desired_mm = v & 16'hFFFF;
			CFG_GAIN:     gain = v & 16'hFFFF;
			CFG_MAX_TURN: max_turn = v & 10'h3FF;
			CFG_DEADBAND: deadband = v & 10'h3FF;
			CFG_LOOKAHD:  look_mm = v & 16'hFFFF;
			CFG_FRONT:    front_ref = v & 16'hFFFF;
			CFG_TIER:     tier_thr = v & 10'h3FF;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic longint pick(input longint hi, input longint typ);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return hi;
			2, 3: return $urandom_range(0, typ);
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	function automatic scan_row_t random_scan();
		scan_row_t row;
		int unsigned sel;
		row = '0;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			// plausible wall geometry with noise
			row.right = 16'($urandom_range(50, 3000));
			row.diag = 16'((row.right * 1414) / 1000 + $urandom_range(0, 800) - 400);
			row.ahead = 16'($urandom_range(0, 4000));
			row.right_ok = 1'b1;
			row.diag_ok = 1'b1;
			row.ahead_ok = ($urandom_range(0, 15) != 0);
		end else begin
			row.right = (sel == 6) ? 16'($urandom_range(0, 3)) : 16'($urandom());
			row.diag = (sel == 7) ? 16'($urandom_range(0, 3)) : 16'($urandom());
			row.ahead = 16'($urandom());
			row.right_ok = $urandom_range(0, 3) != 0;
			row.diag_ok = $urandom_range(0, 3) != 0;
			row.ahead_ok = $urandom_range(0, 3) != 0;
		end
		return row;
	endfunction

	// directed scans; typed results assume reset registers
	scan_row_t directed [19] = '{
		'{16'd0, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 1'b1, '{11'sd300, SPEED_SLOW}},
		'{16'd250, 1'b0, 16'd354, 1'b1, 16'd1000, 1'b1, 1'b1, '{11'sd300, SPEED_SLOW}},
		'{16'd250, 1'b1, 16'd354, 1'b0, 16'd1000, 1'b1, 1'b1, '{11'sd300, SPEED_SLOW}},
		'{16'd250, 1'b1, 16'd354, 1'b1, 16'd65535, 1'b0, 1'b1, '{11'sd300, SPEED_SLOW}},
		'{16'd250, 1'b1, 16'd354, 1'b1, 16'd299, 1'b1, 1'b1, '{11'sd300, SPEED_SLOW}},
		'{16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b1, '{11'sd300, SPEED_SLOW}},
		'{16'd250, 1'b1, 16'd354, 1'b1, 16'd300, 1'b1, 1'b0, '0},
		'{16'd250, 1'b1, 16'd354, 1'b1, 16'd1000, 1'b1, 1'b0, '0},
		'{16'hFFFF, 1'b1, 16'd0, 1'b1, 16'hFFFF, 1'b1, 1'b0, '0},
		'{16'd1, 1'b1, 16'd0, 1'b1, 16'd5000, 1'b1, 1'b0, '0},
		'{16'd0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, '0},
		'{16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, '0},
		'{16'hFFFF, 1'b1, 16'd1, 1'b1, 16'd400, 1'b1, 1'b0, '0},
		'{16'd300, 1'b1, 16'd300, 1'b1, 16'd2000, 1'b1, 1'b0, '0},
		'{16'd200, 1'b1, 16'd283, 1'b1, 16'd2000, 1'b1, 1'b0, '0},
		'{16'd600, 1'b1, 16'd500, 1'b1, 16'd2000, 1'b1, 1'b0, '0},
		'{16'd100, 1'b1, 16'd2000, 1'b1, 16'd2000, 1'b1, 1'b0, '0},
		'{16'h5555, 1'b1, 16'hAAAA, 1'b1, 16'h5555, 1'b1, 1'b0, '0},
		'{16'hAAAA, 1'b1, 16'h5555, 1'b1, 16'hAAAA, 1'b1, 1'b0, '0}
	};

	initial begin
		scan_row_t row;
		int burst;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DESIRED;
		cfg_data = '0;
		next_typed = 1'b0;
		next_cmd = '0;
		rx_mode = 0;
		errors = 0;
		cycles = 0;
		desired_mm = 250;
		gain = 384;
		max_turn = 300;
		deadband = 10;
		look_mm = 200;
		front_ref = 300;
		tier_thr = 124;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_scan(directed[i]);
		drain();
		write_reg(CFG_UNUSED, 16'h1234);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: begin
						write_reg(CFG_DESIRED, 65535);
						write_reg(CFG_GAIN, 65535);
						write_reg(CFG_MAX_TURN, 1000);
						write_reg(CFG_DEADBAND, 1000);
						write_reg(CFG_LOOKAHD, 65535);
						write_reg(CFG_FRONT, 65535);
						write_reg(CFG_TIER, 1000);
					end
					2: begin
						write_reg(CFG_DESIRED, 0);
						write_reg(CFG_GAIN, 0);
						write_reg(CFG_MAX_TURN, 0);
						write_reg(CFG_DEADBAND, 0);
						write_reg(CFG_LOOKAHD, 0);
						write_reg(CFG_FRONT, 0);
						write_reg(CFG_TIER, 0);
					end
					default: begin
						write_reg(CFG_DESIRED, pick(65535, 600));
						write_reg(CFG_GAIN, pick(65535, 1024));
						write_reg(CFG_MAX_TURN, pick(1000, 1000));
						write_reg(CFG_DEADBAND, pick(1000, 40));
						write_reg(CFG_LOOKAHD, pick(65535, 500));
						write_reg(CFG_FRONT, pick(65535, 600));
						write_reg(CFG_TIER, pick(1000, 400));
					end
				endcase
			end
			// bursts of random length with random gaps
			for (int n = 0; n < RANDOM_ITEMS / 5; ) begin
				burst = $urandom_range(1, 40);
				for (int k = 0; k < burst && n < RANDOM_ITEMS / 5; k++, n++) begin
					row = random_scan();
					send_scan(row);
				end
				if ($urandom_range(0, 30) == 0)
					drain();
				else if ($urandom_range(0, 2) != 0)
					pause_sender($urandom_range(0, 8));
			end
		end

		drain();
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
